// File: sv/lzp_pkg.sv
// Shared types and constants for the LZ token stream parser.
package lzp_pkg;

    // Result kind codes.
    localparam logic [1:0] KIND_LIT   = 2'd0;
    localparam logic [1:0] KIND_MATCH = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    // The end token reports the decoded length clipped to 24 bits.
    localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;

    // Result queue geometry: room for two pushes on top of two held entries.
    localparam int QDEPTH = 4;
    localparam int QCNT_W = 3;

    // One result beat.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  lit_byte;
        logic [14:0] match_length;
        logic [21:0] match_distance;
        logic [23:0] total_length;
        logic        last;
    } result_t;

endpackage

// File: sv/lz_token_stream_parser_core.sv
// Top level of the LZ token stream parser: token decode, state and result queue.
//
// The parser takes one compressed byte per cycle while its result queue has room
// and puts out literal beats, match commands (length and backward distance), an end
// beat with the saturated decoded length, or an error beat for the reserved tag;
// after an end or error beat it drops all input until reset. Each byte is decoded
// in the cycle it is accepted and its results, up to two, enter a four-entry result
// queue, which registers them before they reach the output. Input is taken whenever
// the queue holds two or fewer results, so with a downstream that takes a beat every
// cycle the sustained rate is one byte per cycle; the literal that closes a match
// token yields two beats, the literal and its match command.
module lz_token_stream_parser_core
    import lzp_pkg::*;
#(
    parameter int OUT_COUNT_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  lit_byte,
    output logic [14:0] match_length,
    output logic [21:0] match_distance,
    output logic [23:0] total_length,
    output logic        last
);

    localparam logic [1:0] PH_TOKEN  = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_LITS   = 2'd2;
    localparam logic [1:0] PH_HALT   = 2'd3;

    localparam int WB = (OUT_COUNT_BITS > 24) ? OUT_COUNT_BITS : 24;

    logic [1:0]                phase_reg, phase_next;
    logic [47:0]               hdr_reg, hdr_next;
    logic [2:0]                hcnt_reg, hcnt_next;
    logic [12:0]               lits_reg, lits_next;
    logic                      mpend_reg, mpend_next;
    logic [14:0]               plen_reg, plen_next;
    logic [21:0]               pdist_reg, pdist_next;
    logic [OUT_COUNT_BITS-1:0] bytes_reg, bytes_next;

    logic                      in_accept;
    logic                      room;
    logic [1:0]                push_n;
    result_t [1:0]             push_data;
    result_t                   head;

    logic [47:0]               hdr_new;
    logic [2:0]                hcnt_new;
    logic                      hd_done;
    logic                      hd_match;
    logic [12:0]               hd_rl;
    logic [14:0]               hd_len;
    logic [21:0]               hd_dist;
    logic [2:0]                lm_p;
    logic [2:0]                lm_need;
    logic [23:0]               lm_t2;
    logic [9:0]                lr_units;

    logic [15:0]               add_amt;
    logic [OUT_COUNT_BITS:0]   sum;
    logic [WB-1:0]             bytes_wide;
    logic [23:0]               total24;
    logic [12:0]               lits_dec;

    assign in_ready  = room;
    assign in_accept = in_valid && in_ready;

    // Header byte merge: the new byte lands at the current count.
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            hdr_new[8*k +: 8] = (hcnt_reg == 3'(k)) ? in_byte : hdr_reg[8*k +: 8];
        end
    end
    assign hcnt_new = hcnt_reg + 3'd1;

    // Long match layout: the length field takes one or two bytes, the distance two or three.
    assign lm_p     = hdr_new[8] ? 3'd3 : 3'd2;
    assign lm_t2    = hdr_new[8] ? hdr_new[47:24] : hdr_new[39:16];
    assign lm_need  = lm_p + (lm_t2[0] ? 3'd3 : 3'd2);
    assign lr_units = 10'(hdr_new[15:7]) + 10'd1;

    // Header completion and field extraction, selected by the first clear bit of byte 0.
    always_comb
    begin
        hd_match = 1'b1;
        hd_rl    = '0;
        hd_len   = '0;
        hd_dist  = '0;
        hd_done  = 1'b0;
        priority if (!hdr_new[0])
        begin
            hd_done = (hcnt_new >= 3'd2);
            hd_rl   = 13'(hdr_new[3:1]);
            hd_len  = 15'(hdr_new[6:4]) + 15'd3;
            hd_dist = 22'(hdr_new[15:7]);
        end
        else if (!hdr_new[1])
        begin
            hd_done = (hcnt_new >= 3'd3);
            hd_rl   = 13'(hdr_new[4:2]);
            hd_len  = 15'(hdr_new[10:5]) + 15'd4;
            hd_dist = 22'(hdr_new[23:11]);
        end
        else if (!hdr_new[2])
        begin
            hd_done = (hcnt_new >= 3'd4);
            hd_rl   = 13'(hdr_new[5:3]);
            hd_len  = 15'(hdr_new[14:6]) + 15'd4;
            hd_dist = 22'(hdr_new[31:15]);
        end
        else if (!hdr_new[4])
        begin
            hd_done = (hcnt_new >= lm_need);
            hd_rl   = 13'(hdr_new[7:5]);
            hd_len  = hdr_new[8] ? (15'(hdr_new[23:10]) + 15'd4)
                                 : (15'(hdr_new[15:9]) + 15'd4);
            hd_dist = lm_t2[0] ? lm_t2[23:2] : 22'(lm_t2[15:1]);
        end
        else
        begin
            // Long raw run.
            hd_done  = (hcnt_new >= 3'd2);
            hd_match = 1'b0;
            hd_rl    = {lr_units, 3'b000};
        end
    end

    // Decoded length as reported by the end token.
    assign bytes_wide = WB'(bytes_reg);
    assign total24    = (bytes_wide > WB'(TOTAL_MAX)) ? TOTAL_MAX : bytes_wide[23:0];
    assign lits_dec   = lits_reg - 13'(lits_reg != '0);

    // Per-beat decode: next state and the results this byte causes.
    always_comb
    begin
        phase_next = phase_reg;
        hdr_next   = hdr_reg;
        hcnt_next  = hcnt_reg;
        lits_next  = lits_reg;
        mpend_next = mpend_reg;
        plen_next  = plen_reg;
        pdist_next = pdist_reg;
        push_n     = 2'd0;
        push_data  = '0;
        add_amt    = '0;
        if (in_accept)
        begin
            unique case (phase_reg)
                PH_TOKEN:
                begin
                    priority if (in_byte[3:0] == 4'h7)
                    begin
                        lits_next  = 13'({5'(in_byte[7:4]) + 5'd1, 3'b000});
                        mpend_next = 1'b0;
                        phase_next = PH_LITS;
                    end
                    else if (in_byte[5:0] == 6'h1F)
                    begin
                        if (in_byte[7:6] == 2'd0)
                        begin
                            push_n                    = 2'd1;
                            push_data[0].kind         = KIND_END;
                            push_data[0].total_length = total24;
                            push_data[0].last         = 1'b1;
                            phase_next                = PH_HALT;
                        end
                        else
                        begin
                            lits_next  = 13'(in_byte[7:6]);
                            mpend_next = 1'b0;
                            phase_next = PH_LITS;
                        end
                    end
                    else if (in_byte[6:0] == 7'h7F)
                    begin
                        push_n            = 2'd1;
                        push_data[0].kind = KIND_ERR;
                        push_data[0].last = 1'b1;
                        phase_next        = PH_HALT;
                    end
                    else
                    begin
                        hdr_next   = {40'd0, in_byte};
                        hcnt_next  = 3'd1;
                        phase_next = PH_HEADER;
                    end
                end
                PH_HEADER:
                begin
                    hdr_next  = hdr_new;
                    hcnt_next = hcnt_new;
                    if (hd_done)
                    begin
                        hcnt_next  = 3'd0;
                        lits_next  = hd_rl;
                        mpend_next = hd_match;
                        plen_next  = hd_len;
                        pdist_next = hd_dist;
                        phase_next = PH_LITS;
                        // A match with no literals issues its command right away.
                        if (hd_match && (hd_rl == '0))
                        begin
                            push_n                      = 2'd1;
                            push_data[0].kind           = KIND_MATCH;
                            push_data[0].match_length   = hd_len;
                            push_data[0].match_distance = hd_dist;
                            push_data[0].last           = 1'b1;
                            add_amt                     = 16'(hd_len);
                            mpend_next                  = 1'b0;
                            phase_next                  = PH_TOKEN;
                        end
                    end
                end
                PH_LITS:
                begin
                    push_n                = 2'd1;
                    push_data[0].kind     = KIND_LIT;
                    push_data[0].lit_byte = in_byte;
                    push_data[0].last     = 1'b1;
                    add_amt               = 16'd1;
                    lits_next             = lits_dec;
                    if (lits_dec == '0)
                    begin
                        phase_next = PH_TOKEN;
                        if (mpend_reg)
                        begin
                            push_n                      = 2'd2;
                            push_data[0].last           = 1'b0;
                            push_data[1].kind           = KIND_MATCH;
                            push_data[1].match_length   = plen_reg;
                            push_data[1].match_distance = pdist_reg;
                            push_data[1].last           = 1'b1;
                            add_amt                     = 16'(plen_reg) + 16'd1;
                            mpend_next                  = 1'b0;
                        end
                    end
                end
                PH_HALT:
                begin
                    // Input is dropped until reset.
                end
            endcase
        end
    end

    // Saturating output byte count.
    assign sum        = {1'b0, bytes_reg} + (OUT_COUNT_BITS + 1)'(add_amt);
    assign bytes_next = sum[OUT_COUNT_BITS] ? '1 : sum[OUT_COUNT_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TOKEN;
            hdr_reg   <= '0;
            hcnt_reg  <= '0;
            lits_reg  <= '0;
            mpend_reg <= 1'b0;
            plen_reg  <= '0;
            pdist_reg <= '0;
            bytes_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            hcnt_reg  <= hcnt_next;
            lits_reg  <= lits_next;
            mpend_reg <= mpend_next;
            plen_reg  <= plen_next;
            pdist_reg <= pdist_next;
            if (in_accept)
            begin
                bytes_reg <= bytes_next;
            end
        end
    end

    // Result queue decouples the output handshake from decode.
    lzp_result_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_n     (push_n),
        .push_data  (push_data),
        .pop_ready  (out_ready),
        .head_valid (out_valid),
        .head       (head),
        .room       (room)
    );

    assign kind           = head.kind;
    assign lit_byte       = head.lit_byte;
    assign match_length   = head.match_length;
    assign match_distance = head.match_distance;
    assign total_length   = head.total_length;
    assign last           = head.last;

endmodule

// File: sv/lzp_result_queue.sv
// Small shifting result queue: up to two pushes and one pop per cycle.
module lzp_result_queue
    import lzp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_n,
    input  result_t [1:0]     push_data,
    input  logic              pop_ready,
    output logic              head_valid,
    output result_t           head,
    output logic              room
);

    result_t               ent_reg  [QDEPTH];
    result_t               ent_next [QDEPTH];
    logic [QCNT_W-1:0]     count_reg;
    logic [QCNT_W-1:0]     count_next;
    logic                  pop;
    logic [QCNT_W-1:0]     base;

    // The head entry always sits in slot zero.
    assign head_valid = (count_reg != '0);
    assign head       = ent_reg[0];
    assign pop        = head_valid && pop_ready;

    // Two free slots are needed to take any input beat.
    assign room = (count_reg <= QCNT_W'(QDEPTH - 2));

    assign base       = count_reg - QCNT_W'(pop);
    assign count_next = base + QCNT_W'(push_n);

    // Shift on pop, then drop new results in behind the survivors.
    always_comb
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            ent_next[i] = ent_reg[i];
        end
        if (pop)
        begin
            for (int i = 0; i < QDEPTH - 1; i++)
            begin
                ent_next[i] = ent_reg[i + 1];
            end
        end
        for (int i = 0; i < QDEPTH; i++)
        begin
            if ((push_n != 2'd0) && (base == QCNT_W'(i)))
            begin
                ent_next[i] = push_data[0];
            end
            if ((push_n == 2'd2) && ((base + QCNT_W'(1)) == QCNT_W'(i)))
            begin
                ent_next[i] = push_data[1];
            end
        end
    end

    // Entry payload needs no reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            ent_reg[i] <= ent_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/lzp_checker.sv
// Port-level checks for the LZ token stream parser, bound to the top level.
module lzp_checker
    import lzp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [7:0]  lit_byte,
    input logic [14:0] match_length,
    input logic [21:0] match_distance,
    input logic [23:0] total_length,
    input logic        last
);

    // A stalled result beat holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(lit_byte)
            && $stable(match_length) && $stable(match_distance) && $stable(total_length)
            && $stable(last))
        else $error("result beat changed while stalled");

    // A literal that is not last is followed at once by its match command.
    a_lit_then_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (kind == KIND_LIT) && !last
            |=> out_valid && (kind == KIND_MATCH) && last)
        else $error("literal not followed by match command");

    // Nothing follows an end or error beat.
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && ((kind == KIND_END) || (kind == KIND_ERR))
            |=> !out_valid)
        else $error("result after end or error");

    // Match commands always copy at least three bytes; other beats carry no copy.
    a_match_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == KIND_MATCH) ? (match_length >= 15'd3)
                       : ((match_length == '0) && (match_distance == '0))))
        else $error("bad match fields");

endmodule

bind lz_token_stream_parser_core lzp_checker u_lzp_checker (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for the LZ token stream parser core.
module testbench;
    import lzp_pkg::*;

    localparam int RANDOM_BYTES = 650;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 20;

    // Parser phases as the predictor tracks them.
    typedef enum logic [1:0] {AWAIT_TOKEN, IN_HEADER, IN_LITERALS, HALTED} parse_phase_t;

    // One row of the directed stimulus; a typed row carries its expected beat.
    typedef struct {
        logic [7:0] data;
        bit         typed;
        result_t    beat;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  lit_byte;
    logic [14:0] match_length;
    logic [21:0] match_distance;
    logic [23:0] total_length;
    logic        last;

    // Predictor state.
    parse_phase_t parse_phase = AWAIT_TOKEN;
    logic [47:0]  hdr = '0;
    int           hdr_cnt = 0;
    int           lits_left = 0;
    bit           match_owed = 1'b0;
    logic [14:0]  owed_len = '0;
    logic [21:0]  owed_dist = '0;
    logic [23:0]  decoded_total = '0;

    // Beats produced by the last predicted byte, and beats still to arrive.
    result_t step_beats [2];
    int      step_count;
    result_t decoded_beats [$];

    int bytes_taken = 0;
    int errors = 0;
    int cycles = 0;
    int gap_pct = 0;
    int stall_pct = 0;

    // Directed stimulus: match extremes, a match closed by a literal, a tiny raw run.
    stim_row_t dir_rows [26] = '{
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_MATCH, 8'h00, 15'd3, 22'd0, 24'd0, 1'b1}},
        '{8'hF0, 1'b0, '0},
        '{8'hFF, 1'b1, '{KIND_MATCH, 8'h00, 15'd10, 22'd511, 24'd0, 1'b1}},
        '{8'h0F, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_MATCH, 8'h00, 15'd4, 22'd0, 24'd0, 1'b1}},
        '{8'h0F, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b1, '{KIND_MATCH, 8'h00, 15'd16387, 22'd4194303, 24'd0, 1'b1}},
        '{8'h03, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b1, '{KIND_MATCH, 8'h00, 15'd512, 22'd131071, 24'd0, 1'b1}},
        '{8'h05, 1'b0, '0},
        '{8'hAB, 1'b0, '0},
        '{8'hCD, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hDF, 1'b0, '0},
        '{8'hFF, 1'b1, '{KIND_LIT, 8'hFF, 15'd0, 22'd0, 24'd0, 1'b1}},
        '{8'h80, 1'b1, '{KIND_LIT, 8'h80, 15'd0, 22'd0, 24'd0, 1'b1}},
        '{8'h01, 1'b1, '{KIND_LIT, 8'h01, 15'd0, 22'd0, 24'd0, 1'b1}}
    };

    lz_token_stream_parser_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .lit_byte       (lit_byte),
        .match_length   (match_length),
        .match_distance (match_distance),
        .total_length   (total_length),
        .last           (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] any_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    function automatic result_t mk_beat(logic [1:0] k, logic [7:0] lit, logic [14:0] len,
                                        logic [21:0] cp_dist, logic [23:0] tot);
        result_t r;
        r.kind = k;
        r.lit_byte = lit;
        r.match_length = len;
        r.match_distance = cp_dist;
        r.total_length = tot;
        r.last = 1'b0;
        return r;
    endfunction

    // Header length of the token held so far; one more than the count while still open.
    function automatic int header_length(logic [47:0] h, int cnt);
        int p;
        if (!h[0])
            return 2;
        if (!h[1])
            return 3;
        if (!h[2])
            return 4;
        if (!h[4])
        begin
            if (cnt < 2)
                return cnt + 1;
            p = h[8] ? 3 : 2;
            if (cnt <= p)
                return cnt + 1;
            return p + (h[8 * p] ? 3 : 2);
        end
        return 2;
    endfunction

    task automatic emit_beat(input result_t r);
        step_beats[step_count] = r;
        step_count++;
    endtask

    // The decoded length saturates at the top of its 24-bit range.
    task automatic add_to_total(input int n);
        logic [24:0] s;
        s = decoded_total + n;
        decoded_total = (s > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : s[23:0];
    endtask

    // Predicts the beats that one accepted stream byte causes.
    task automatic decode_stream_byte(input logic [7:0] b);
        int          rl;
        int          len;
        logic [21:0] cp_dist;
        logic [47:0] h;
        logic [47:0] t2;
        bit          is_match;
        step_count = 0;
        case (parse_phase)
            AWAIT_TOKEN:
            begin
                if (b[3:0] == 4'h7)
                begin
                    lits_left = (b[7:4] + 1) * 8;
                    match_owed = 1'b0;
                    parse_phase = IN_LITERALS;
                end
                else if (b[5:0] == 6'h1F)
                begin
                    if (b[7:6] == 2'd0)
                    begin
                        emit_beat(mk_beat(KIND_END, 8'd0, 15'd0, 22'd0, decoded_total));
                        parse_phase = HALTED;
                    end
                    else
                    begin
                        lits_left = b[7:6];
                        match_owed = 1'b0;
                        parse_phase = IN_LITERALS;
                    end
                end
                else if (b[6:0] == 7'h7F)
                begin
                    emit_beat(mk_beat(KIND_ERR, 8'd0, 15'd0, 22'd0, 24'd0));
                    parse_phase = HALTED;
                end
                else
                begin
                    hdr = {40'd0, b};
                    hdr_cnt = 1;
                    parse_phase = IN_HEADER;
                end
            end
            IN_HEADER:
            begin
                hdr[8 * hdr_cnt +: 8] = b;
                hdr_cnt++;
                if (hdr_cnt >= header_length(hdr, hdr_cnt))
                begin
                    h = hdr;
                    is_match = 1'b1;
                    len = 0;
                    cp_dist = '0;
                    if (!h[0])
                    begin
                        rl = h[3:1];
                        len = h[6:4] + 3;
                        cp_dist = h[15:7];
                    end
                    else if (!h[1])
                    begin
                        rl = h[4:2];
                        len = h[10:5] + 4;
                        cp_dist = h[23:11];
                    end
                    else if (!h[2])
                    begin
                        rl = h[5:3];
                        len = h[14:6] + 4;
                        cp_dist = h[31:15];
                    end
                    else if (!h[4])
                    begin
                        // Long match: one or two length bytes, then two or three distance bytes.
                        rl = h[7:5];
                        if (!h[8])
                        begin
                            len = h[15:9] + 4;
                            t2 = h >> 16;
                        end
                        else
                        begin
                            len = h[23:10] + 4;
                            t2 = h >> 24;
                        end
                        if (!t2[0])
                            cp_dist = t2[15:1];
                        else
                            cp_dist = t2[23:2];
                    end
                    else
                    begin
                        rl = (h[15:7] + 1) * 8;
                        is_match = 1'b0;
                    end
                    hdr_cnt = 0;
                    lits_left = rl;
                    match_owed = is_match;
                    owed_len = len;
                    owed_dist = cp_dist;
                    parse_phase = IN_LITERALS;
                    // A match with no literals is issued on its last header byte.
                    if (is_match && rl == 0)
                    begin
                        emit_beat(mk_beat(KIND_MATCH, 8'd0, owed_len, owed_dist, 24'd0));
                        add_to_total(len);
                        match_owed = 1'b0;
                        parse_phase = AWAIT_TOKEN;
                    end
                end
            end
            IN_LITERALS:
            begin
                emit_beat(mk_beat(KIND_LIT, b, 15'd0, 22'd0, 24'd0));
                add_to_total(1);
                if (lits_left > 0)
                    lits_left--;
                if (lits_left == 0)
                begin
                    if (match_owed)
                    begin
                        emit_beat(mk_beat(KIND_MATCH, 8'd0, owed_len, owed_dist, 24'd0));
                        add_to_total(owed_len);
                        match_owed = 1'b0;
                    end
                    parse_phase = AWAIT_TOKEN;
                end
            end
            default:
                ;
        endcase
        if (step_count > 0)
            step_beats[step_count - 1].last = 1'b1;
    endtask

    // Offers one byte, waits for its handshake and records the beats it should cause.
    task automatic send_byte(input logic [7:0] b, input bit typed, input result_t beat);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_taken++;
        decode_stream_byte(b);
        if (typed)
            decoded_beats.push_back(beat);
        else
            for (int i = 0; i < step_count; i++)
                decoded_beats.push_back(step_beats[i]);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Output side: check every beat taken, then decide whether to stall next cycle.
    always @(posedge clk)
    begin : take_beats
        result_t seen;
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen = {kind, lit_byte, match_length, match_distance, total_length, last};
                if (decoded_beats.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat: kind %0d lit %0d len %0d dist %0d total %0d",
                             $time, kind, lit_byte, match_length, match_distance, total_length);
                end
                else
                begin
                    want = decoded_beats.pop_front();
                    compare_field("kind", want.kind, seen.kind);
                    compare_field("lit_byte", want.lit_byte, seen.lit_byte);
                    compare_field("match_length", want.match_length, seen.match_length);
                    compare_field("match_distance", want.match_distance, seen.match_distance);
                    compare_field("total_length", want.total_length, seen.total_length);
                    compare_field("last", want.last, seen.last);
                end
            end
            out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int         start;
        int         pick;
        int         lits;
        int         ending;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] hdr_q [$];

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows, no idling.
        foreach (dir_rows[i])
            send_byte(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].beat);

        // Random tokens with random content, with a little noise mixed in.
        start = bytes_taken;
        while (bytes_taken - start < RANDOM_BYTES)
        begin
            case ((bytes_taken - start) * 5 / RANDOM_BYTES)
                1:
                begin
                    gap_pct = 64;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct = 64;
                end
                3:
                begin
                    gap_pct = 20;
                    stall_pct = 20;
                end
                default:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
            endcase
            if ($urandom_range(9) == 0)
            begin
                // Noise bytes, steering clear of the end and reserved tags and of long raw runs.
                repeat ($urandom_range(1, 4))
                begin
                    b0 = any_byte();
                    while (parse_phase == AWAIT_TOKEN &&
                           (b0 == 8'h1F || b0[6:0] == 7'h7F || b0[6:0] == 7'h3F))
                        b0 = any_byte();
                    send_byte(b0, 1'b0, '0);
                end
                // Bring the parser back to a token boundary.
                while (parse_phase != AWAIT_TOKEN)
                    send_byte(any_byte(), 1'b0, '0);
            end
            else
            begin
                hdr_q = {};
                pick = $urandom_range(6);
                b0 = any_byte();
                case (pick)
                    0:
                    begin
                        b0[0] = 1'b0;
                        lits = b0[3:1];
                        hdr_q.push_back(b0);
                        hdr_q.push_back(any_byte());
                    end
                    1:
                    begin
                        b0[1:0] = 2'b01;
                        lits = b0[4:2];
                        hdr_q.push_back(b0);
                        repeat (2) hdr_q.push_back(any_byte());
                    end
                    2:
                    begin
                        b0[2:0] = 3'b011;
                        lits = b0[5:3];
                        hdr_q.push_back(b0);
                        repeat (3) hdr_q.push_back(any_byte());
                    end
                    3:
                    begin
                        // Raw run: mostly short, now and then up to the full 128.
                        b0[3:0] = 4'h7;
                        if ($urandom_range(7) != 0)
                            b0[7:4] = {3'b000, b0[4]};
                        lits = (b0[7:4] + 1) * 8;
                        hdr_q.push_back(b0);
                    end
                    4:
                    begin
                        b0[4:0] = 5'h0F;
                        lits = b0[7:5];
                        hdr_q.push_back(b0);
                        b1 = any_byte();
                        hdr_q.push_back(b1);
                        if (b1[0])
                            hdr_q.push_back(any_byte());
                        b1 = any_byte();
                        hdr_q.push_back(b1);
                        hdr_q.push_back(any_byte());
                        if (b1[0])
                            hdr_q.push_back(any_byte());
                    end
                    5:
                    begin
                        b0[5:0] = 6'h1F;
                        if (b0[7:6] == 2'd0)
                            b0[6] = 1'b1;
                        lits = b0[7:6];
                        hdr_q.push_back(b0);
                    end
                    default:
                    begin
                        // Long raw run: mostly small counts, rarely the full range.
                        b0[6:0] = 7'h3F;
                        b1 = any_byte();
                        if ($urandom_range(19) != 0)
                            b1[7:2] = 6'd0;
                        lits = ({b1, b0[7]} + 1) * 8;
                        hdr_q.push_back(b0);
                        hdr_q.push_back(b1);
                    end
                endcase
                foreach (hdr_q[i])
                    send_byte(hdr_q[i], 1'b0, '0);
                repeat (lits) send_byte(any_byte(), 1'b0, '0);
            end
        end

        // Close whatever token is still open.
        while (parse_phase != AWAIT_TOKEN)
            send_byte(any_byte(), 1'b0, '0);

        // Finish with a reserved tag or a plain end.
        ending = $urandom_range(1);
        if (ending == 0)
        begin
            send_byte(any_byte() | 8'h7F, 1'b1, '{KIND_ERR, 8'd0, 15'd0, 22'd0, 24'd0, 1'b1});
        end
        else
        begin
            send_byte(8'h1F, 1'b0, '0);
        end

        // Bytes after a halt must be dropped.
        repeat (6) send_byte(any_byte(), 1'b0, '0);
        in_valid <= 1'b0;

        while (decoded_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
